// ===== rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int VAL_W        = 32;
  localparam int SUM_W        = 36;
  localparam int CNT_OUT_W    = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] item_value;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [VAL_W-1:0]     popped_value;
    logic [CNT_OUT_W-1:0]        entry_count;
    logic signed [SUM_W-1:0]     total_sum;
  } spq_rsp_t;

  // Broadcast to every cell; shift only happens when en is set.
  typedef struct packed {
    logic                    en;
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
  } spq_cmd_t;

  typedef struct packed {
    logic le;  // holds a value <= the broadcast value
    logic eq;
    logic ge;
  } spq_flag_t;

endpackage
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One storage cell of the sorted chain: compares against the broadcast value and shifts.
`default_nettype none
module spq_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                              clk,
  input  wire spq_pkg::spq_cmd_t                 cmd,
  input  wire logic [CNT_W-1:0]                  count,
  input  wire logic                              left_le,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  left_value,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  right_value,
  output spq_pkg::spq_flag_t                     flags,
  output logic signed [spq_pkg::VAL_W-1:0]       value
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic signed [spq_pkg::VAL_W-1:0] value_r;
  logic signed [spq_pkg::VAL_W-1:0] value_nxt;
  logic                             occupied;

  assign occupied = IDX_C < count;
  assign value    = value_r;

  always_comb begin
    flags.le = occupied && (value_r <= cmd.value);
    flags.eq = occupied && (value_r == cmd.value);
    flags.ge = occupied && (value_r >= cmd.value);
  end

  // cmd.en already folds in full / empty / not-found checks.
  always_comb begin
    value_nxt = value_r;
    if (cmd.en) begin
      case (cmd.op)
        spq_pkg::REQ_INSERT: begin
          if (!flags.le) begin
            value_nxt = left_le ? cmd.value : left_value;
          end
        end
        spq_pkg::REQ_POP: begin
          value_nxt = right_value;
        end
        spq_pkg::REQ_REMOVE: begin
          // sorted order: first match is the first cell >= value
          if (flags.ge) begin
            value_nxt = right_value;
          end
        end
        default: begin
          value_nxt = value_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count, sum and result register.
// Sorted priority queue: holds up to CAPACITY signed 32-bit values in ascending order in
// a chain of cells. For insert, pop-minimum and remove-by-value, all cells compare against
// the request value in parallel and shift left or right by one in the cycle the item is
// accepted, so a new item can be accepted every cycle while the output is not stalled. The
// result sits in an output register and appears the cycle after acceptance; the input stays
// ready while that register is empty or being drained. Throughput is bounded by the
// compare-and-shift of the cell chain plus the found-flag OR across all cells.
`default_nettype none
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spq_pkg::spq_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output spq_pkg::spq_rsp_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic signed [spq_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                             out_valid_r, out_valid_nxt;
  spq_pkg::spq_rsp_t                out_data_r, out_data_nxt;

  spq_pkg::spq_cmd_t                cmd;
  spq_pkg::spq_flag_t               flags [CAPACITY];
  logic signed [spq_pkg::VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]              match_vec;
  logic                             accept, found, is_full, is_empty;
  logic signed [spq_pkg::SUM_W-1:0] val_ext, head_ext;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_full  = count_r >= CAP_C;
  assign is_empty = count_r == '0;
  assign found    = |match_vec;
  assign val_ext  = spq_pkg::SUM_W'(in_data.item_value);
  assign head_ext = spq_pkg::SUM_W'(cell_val[0]);

  always_comb begin
    cmd.op    = in_data.req_type;
    cmd.value = in_data.item_value;
    case (in_data.req_type)
      spq_pkg::REQ_INSERT: cmd.en = accept && !is_full;
      spq_pkg::REQ_POP:    cmd.en = accept && !is_empty;
      spq_pkg::REQ_REMOVE: cmd.en = accept && found;
      default:             cmd.en = 1'b0;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                             l_le;
    logic signed [spq_pkg::VAL_W-1:0] l_val, r_val;

    if (i == 0) begin : g_first
      assign l_le  = 1'b1;
      assign l_val = in_data.item_value;
    end else begin : g_mid
      assign l_le  = flags[i-1].le;
      assign l_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_val = cell_val[i];
    end else begin : g_inner
      assign r_val = cell_val[i+1];
    end

    assign match_vec[i] = flags[i].eq;

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .left_le     (l_le),
      .left_value  (l_val),
      .right_value (r_val),
      .flags       (flags[i]),
      .value       (cell_val[i])
    );
  end

  always_comb begin
    count_nxt                 = count_r;
    sum_nxt                   = sum_r;
    out_data_nxt              = out_data_r;
    out_data_nxt.status       = spq_pkg::ST_DONE;
    out_data_nxt.popped_value = spq_pkg::NO_VALUE;
    case (in_data.req_type)
      spq_pkg::REQ_INSERT: begin
        if (is_full) begin
          out_data_nxt.status = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          sum_nxt   = sum_r + val_ext;
        end
      end
      spq_pkg::REQ_POP: begin
        if (is_empty) begin
          out_data_nxt.status = spq_pkg::ST_MISS;
        end else begin
          out_data_nxt.popped_value = cell_val[0];
          count_nxt = count_r - 1'b1;
          sum_nxt   = sum_r - head_ext;
        end
      end
      spq_pkg::REQ_REMOVE: begin
        if (!found) begin
          out_data_nxt.status = spq_pkg::ST_MISS;
        end else begin
          count_nxt = count_r - 1'b1;
          sum_nxt   = sum_r - val_ext;
        end
      end
      default: begin
        out_data_nxt.status = spq_pkg::ST_DONE;
      end
    endcase
    out_data_nxt.entry_count = spq_pkg::CNT_OUT_W'(count_nxt);
    out_data_nxt.total_sum   = sum_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire
